// ===== rtl/spc_pkg.sv =====
// Shared types and constants for the shape pair collision test.
package spc_pkg;

   localparam int CW     = 27;   // front component width, signed
   localparam int LW     = 21;   // size sum, radius and penetration width
   localparam int MW     = 26;   // magnitude width going into the squarers
   localparam int D2W    = 42;   // squared distance width when colliding
   localparam int FRAC   = 20;   // extra scale of the square root operand
   localparam int SW     = 31;   // square root width
   localparam int RW     = 33;   // square root remainder width
   localparam int QW     = 15;   // normal quotient width
   localparam int NW     = 47;   // divider remainder width
   localparam int NRMW   = 16;   // normal component width
   localparam int SPC_QUEUE_DEPTH = 4;

   localparam logic [QW-1:0]          ONE_Q14     = 15'd16384;
   localparam logic signed [NRMW-1:0] POS_ONE_Q14 = 16'sh4000;
   localparam logic signed [NRMW-1:0] NEG_ONE_Q14 = 16'shC000;

   localparam logic SHAPE_RECT   = 1'b0;
   localparam logic SHAPE_CIRCLE = 1'b1;

   localparam logic [1:0] PAIR_RECT_RECT     = 2'b00;
   localparam logic [1:0] PAIR_RECT_CIRCLE   = 2'b01;
   localparam logic [1:0] PAIR_CIRCLE_RECT   = 2'b10;
   localparam logic [1:0] PAIR_CIRCLE_CIRCLE = 2'b11;

   typedef struct packed {
      logic                 rect;
      logic signed [CW-1:0] p;
      logic signed [CW-1:0] q;
      logic [LW-1:0]        lx;
      logic [LW-1:0]        ly;
   } spc_item_type;

   typedef struct packed {
      logic                   rect;
      logic                   hit;
      logic [LW-1:0]          pen;
      logic signed [NRMW-1:0] nx;
      logic signed [NRMW-1:0] ny;
      logic [LW-1:0]          lim;
      logic [LW-1:0]          mx;
      logic [LW-1:0]          my;
      logic                   sx;
      logic                   sy;
   } spc_meta_type;

endpackage

// ===== rtl/shape_pair_collision_test.sv =====
// Top level of the 2D shape pair collision test.
//
//   channel | dir | tdata                              | tuser
//   req     | in  | 216 bits, both shapes' geometry    | a_shape, b_shape
//   rsp     | out | 56 bits, colliding/depth/normal    | none
//
// One transaction per cycle sustained while rsp_tready holds; results pass through
// the 31-step square root and the 15-step normal division.
// The front end feeds a small queue, so req_tready drops only when the queue fills.
// A stall on rsp freezes the compute pipeline as a whole.
// Reset empties the queue and the pipeline; no clearing pass.
module shape_pair_collision_test import spc_pkg::*; #(
   parameter int QUEUE_DEPTH = SPC_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x, a_y, a_w, a_h, a_radius, b_x, b_y, b_w, b_h, b_radius
   input  logic [215:0] req_tdata,
   // a_shape, b_shape
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // colliding, penetration, normal_x, normal_y, zero pad
   output logic [55:0]  rsp_tdata
);

   spc_item_type front_item, head_item;
   logic         q_full, q_not_empty, q_pop, push;
   logic         col;
   logic [LW-1:0] pen;
   logic signed [NRMW-1:0] nx, ny;

   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;

   spc_front u_front (
      .a_shape  (req_tuser[0]),
      .a_x      (req_tdata[23:0]),
      .a_y      (req_tdata[47:24]),
      .a_w      (req_tdata[67:48]),
      .a_h      (req_tdata[87:68]),
      .a_radius (req_tdata[107:88]),
      .b_shape  (req_tuser[1]),
      .b_x      (req_tdata[131:108]),
      .b_y      (req_tdata[155:132]),
      .b_w      (req_tdata[175:156]),
      .b_h      (req_tdata[195:176]),
      .b_radius (req_tdata[215:196]),
      .item     (front_item)
   );

   spc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   spc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (q_not_empty),
      .item            (head_item),
      .item_pop        (q_pop),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_colliding   (col),
      .out_penetration (pen),
      .out_normal_x    (nx),
      .out_normal_y    (ny)
   );

   assign rsp_tdata = {2'b00, ny, nx, pen, col};

endmodule

// ===== rtl/spc_front.sv =====
// Front end: classify the shape pair and form the vector and limits.
module spc_front import spc_pkg::*; (
   input  logic                a_shape,
   input  logic signed [23:0]  a_x,
   input  logic signed [23:0]  a_y,
   input  logic [19:0]         a_w,
   input  logic [19:0]         a_h,
   input  logic [19:0]         a_radius,
   input  logic                b_shape,
   input  logic signed [23:0]  b_x,
   input  logic signed [23:0]  b_y,
   input  logic [19:0]         b_w,
   input  logic [19:0]         b_h,
   input  logic [19:0]         b_radius,
   output spc_item_type        item
);

   logic signed [CW-1:0] ax, ay, bx, by, aw, ah, bw, bh;
   logic signed [CW-1:0] axe, aye, bxe, bye;

   assign ax  = CW'(a_x);
   assign ay  = CW'(a_y);
   assign bx  = CW'(b_x);
   assign by  = CW'(b_y);
   assign aw  = CW'({1'b0, a_w});
   assign ah  = CW'({1'b0, a_h});
   assign bw  = CW'({1'b0, b_w});
   assign bh  = CW'({1'b0, b_h});
   assign axe = ax + aw;
   assign aye = ay + ah;
   assign bxe = bx + bw;
   assign bye = by + bh;

   always_comb begin
      item = '0;
      unique case ({a_shape, b_shape})
         PAIR_RECT_RECT: begin
            item.rect = 1'b1;
            item.p    = (bx + bxe) - (ax + axe);
            item.q    = (by + bye) - (ay + aye);
            item.lx   = LW'(a_w) + LW'(b_w);
            item.ly   = LW'(a_h) + LW'(b_h);
         end
         PAIR_CIRCLE_CIRCLE: begin
            item.p  = bx - ax;
            item.q  = by - ay;
            item.lx = LW'(a_radius) + LW'(b_radius);
         end
         PAIR_CIRCLE_RECT: begin
            item.p  = (ax < bx) ? bx - ax : ((ax > bxe) ? bxe - ax : '0);
            item.q  = (ay < by) ? by - ay : ((ay > bye) ? bye - ay : '0);
            item.lx = LW'(a_radius);
         end
         PAIR_RECT_CIRCLE: begin
            item.p  = (bx < ax) ? bx - ax : ((bx > axe) ? bx - axe : '0);
            item.q  = (by < ay) ? by - ay : ((by > aye) ? by - aye : '0);
            item.lx = LW'(b_radius);
         end
         default: item = '0;
      endcase
   end

endmodule

// ===== rtl/spc_queue.sv =====
// Short queue between the front end and the compute pipeline.
module spc_queue import spc_pkg::*; #(
   parameter int DEPTH = SPC_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  spc_item_type push_item,
   input  logic         pop,
   output logic         full,
   output logic         not_empty,
   output spc_item_type head_item
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   spc_item_type      mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNTW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/spc_back.sv =====
// Compute pipeline: overlap test, square root and normal division.
module spc_back import spc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  spc_item_type      item,
   output logic              item_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_colliding,
   output logic [LW-1:0]     out_penetration,
   output logic signed [NRMW-1:0] out_normal_x,
   output logic signed [NRMW-1:0] out_normal_y
);

   logic en;

   // stage 1: magnitudes
   logic              b1_valid_ff;
   logic              b1_rect_ff, b1_sx_ff, b1_sy_ff;
   logic [CW-1:0]     b1_mp_ff, b1_mq_ff;
   logic [LW-1:0]     b1_lx_ff, b1_ly_ff;

   // stage 2: overlaps and squares
   logic                  b2_valid_ff;
   logic                  b2_rect_ff, b2_sx_ff, b2_sy_ff;
   logic signed [CW:0]    b2_ox_ff, b2_oy_ff;
   logic [2*MW-1:0]       b2_px_ff, b2_py_ff;
   logic [2*LW-1:0]       b2_l2_ff;
   logic [LW-1:0]         b2_lx_ff, b2_mp_ff, b2_mq_ff;

   // square root stages
   logic              sq_valid_ff [SW+1];
   spc_meta_type      sq_meta_ff  [SW+1];
   logic [D2W-1:0]    sq_d2_ff    [SW+1];
   logic [RW-1:0]     sq_rem_ff   [SW+1];
   logic [SW-1:0]     sq_root_ff  [SW+1];

   // divider stages
   logic              dv_valid_ff [QW+1];
   spc_meta_type      dv_meta_ff  [QW+1];
   logic [SW-1:0]     dv_s_ff     [QW+1];
   logic [NW-1:0]     dv_rx_ff    [QW+1];
   logic [NW-1:0]     dv_ry_ff    [QW+1];
   logic [QW-1:0]     dv_qx_ff    [QW+1];
   logic [QW-1:0]     dv_qy_ff    [QW+1];

   logic                   out_valid_ff;
   logic                   out_col_ff;
   logic [LW-1:0]          out_pen_ff;
   logic signed [NRMW-1:0] out_nx_ff, out_ny_ff;

   assign en        = !out_valid_ff || out_ready;
   assign item_pop  = en && item_valid;
   assign out_valid = out_valid_ff;
   assign out_colliding   = out_col_ff;
   assign out_penetration = out_pen_ff;
   assign out_normal_x    = out_nx_ff;
   assign out_normal_y    = out_ny_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         b1_rect_ff <= item.rect;
         b1_sx_ff   <= item.p[CW-1];
         b1_sy_ff   <= item.q[CW-1];
         b1_mp_ff   <= item.p[CW-1] ? CW'(-item.p) : CW'(item.p);
         b1_mq_ff   <= item.q[CW-1] ? CW'(-item.q) : CW'(item.q);
         b1_lx_ff   <= item.lx;
         b1_ly_ff   <= item.ly;

         b2_rect_ff <= b1_rect_ff;
         b2_sx_ff   <= b1_sx_ff;
         b2_sy_ff   <= b1_sy_ff;
         b2_ox_ff   <= $signed({7'b0, b1_lx_ff}) - $signed({1'b0, b1_mp_ff});
         b2_oy_ff   <= $signed({7'b0, b1_ly_ff}) - $signed({1'b0, b1_mq_ff});
         b2_px_ff   <= (2*MW)'(b1_mp_ff[MW-1:0]) * (2*MW)'(b1_mp_ff[MW-1:0]);
         b2_py_ff   <= (2*MW)'(b1_mq_ff[MW-1:0]) * (2*MW)'(b1_mq_ff[MW-1:0]);
         b2_l2_ff   <= (2*LW)'(b1_lx_ff) * (2*LW)'(b1_lx_ff);
         b2_lx_ff   <= b1_lx_ff;
         b2_mp_ff   <= b1_mp_ff[LW-1:0];
         b2_mq_ff   <= b1_mq_ff[LW-1:0];
      end
   end

   // stage 3: decide collision, finish the rectangle pair
   spc_meta_type         b3_meta;
   logic [2*MW:0]        b3_d2;
   logic signed [CW:0]   b3_osel, b3_oinc;
   logic                 b3_xaxis;

   always_comb begin
      b3_d2    = {1'b0, b2_px_ff} + {1'b0, b2_py_ff};
      b3_xaxis = b2_ox_ff < b2_oy_ff;
      b3_osel  = b3_xaxis ? b2_ox_ff : b2_oy_ff;
      b3_oinc  = b3_osel + $signed((CW+1)'(1));
      b3_meta      = '0;
      b3_meta.rect = b2_rect_ff;
      b3_meta.lim  = b2_lx_ff;
      b3_meta.mx   = b2_mp_ff;
      b3_meta.my   = b2_mq_ff;
      b3_meta.sx   = b2_sx_ff;
      b3_meta.sy   = b2_sy_ff;
      if (b2_rect_ff) begin
         b3_meta.hit = (b2_ox_ff > 0) && (b2_oy_ff > 0);
         b3_meta.pen = b3_oinc[LW:1];
         if (b3_xaxis) begin
            b3_meta.nx = b2_sx_ff ? NEG_ONE_Q14 : POS_ONE_Q14;
         end else begin
            b3_meta.ny = b2_sy_ff ? NEG_ONE_Q14 : POS_ONE_Q14;
         end
      end else begin
         b3_meta.hit = b3_d2 < (2*MW+1)'(b2_l2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_meta_ff[0] <= b3_meta;
         sq_d2_ff[0]   <= b3_d2[D2W-1:0];
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < SW; j++) begin : g_sqrt
      localparam int I = SW - 1 - j;
      logic [D2W+FRAC-1:0] n_val;
      logic [RW-1:0]       r_sh, t_val;
      logic                ge;
      assign n_val = {sq_d2_ff[j], FRAC'(0)};
      assign r_sh  = {sq_rem_ff[j][RW-3:0], n_val[2*I+1 -: 2]};
      assign t_val = {sq_root_ff[j], 2'b01};
      assign ge    = r_sh >= t_val;
      always_ff @(posedge clock) begin
         if (en) begin
            sq_meta_ff[j+1] <= sq_meta_ff[j];
            sq_d2_ff[j+1]   <= sq_d2_ff[j];
            sq_rem_ff[j+1]  <= ge ? r_sh - t_val : r_sh;
            sq_root_ff[j+1] <= {sq_root_ff[j][SW-2:0], ge};
         end
      end
   end

   // stage after the root: distance, penetration and numerators
   logic [SW:0]     c_rnd;
   spc_meta_type    c_meta;
   logic [SW-1:0]   c_s;

   always_comb begin
      c_s    = sq_root_ff[SW];
      c_rnd  = {1'b0, c_s} + (SW+1)'(512);
      c_meta = sq_meta_ff[SW];
      if (!c_meta.rect) begin
         c_meta.pen = c_meta.lim - c_rnd[LW+9:10];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_meta_ff[0] <= c_meta;
         dv_s_ff[0]    <= c_s;
         dv_rx_ff[0]   <= NW'({c_meta.mx, 24'b0}) + NW'(c_s[SW-1:1]);
         dv_ry_ff[0]   <= NW'({c_meta.my, 24'b0}) + NW'(c_s[SW-1:1]);
         dv_qx_ff[0]   <= '0;
         dv_qy_ff[0]   <= '0;
      end
   end

   for (genvar t = 0; t < QW; t++) begin : g_div
      localparam int K = QW - 1 - t;
      logic [NW-1:0] dvs;
      logic          gex, gey;
      assign dvs = NW'(dv_s_ff[t]) << K;
      assign gex = dv_rx_ff[t] >= dvs;
      assign gey = dv_ry_ff[t] >= dvs;
      always_ff @(posedge clock) begin
         if (en) begin
            dv_meta_ff[t+1] <= dv_meta_ff[t];
            dv_s_ff[t+1]    <= dv_s_ff[t];
            dv_rx_ff[t+1]   <= gex ? dv_rx_ff[t] - dvs : dv_rx_ff[t];
            dv_ry_ff[t+1]   <= gey ? dv_ry_ff[t] - dvs : dv_ry_ff[t];
            dv_qx_ff[t+1]   <= {dv_qx_ff[t][QW-2:0], gex};
            dv_qy_ff[t+1]   <= {dv_qy_ff[t][QW-2:0], gey};
         end
      end
   end

   // result assembly
   spc_meta_type           f_meta;
   logic [QW-1:0]          f_qx, f_qy;
   logic signed [NRMW-1:0] f_nx, f_ny;

   always_comb begin
      f_meta = dv_meta_ff[QW];
      f_qx   = (dv_s_ff[QW] == '0) ? '0 : dv_qx_ff[QW];
      f_qy   = (dv_s_ff[QW] == '0) ? '0 : dv_qy_ff[QW];
      if (f_qx > ONE_Q14) f_qx = ONE_Q14;
      if (f_qy > ONE_Q14) f_qy = ONE_Q14;
      f_nx = f_meta.sx ? -$signed({1'b0, f_qx}) : $signed({1'b0, f_qx});
      f_ny = f_meta.sy ? -$signed({1'b0, f_qy}) : $signed({1'b0, f_qy});
      if (f_meta.rect) begin
         f_nx = f_meta.nx;
         f_ny = f_meta.ny;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_col_ff <= f_meta.hit;
         out_pen_ff <= f_meta.hit ? f_meta.pen : '0;
         out_nx_ff  <= f_meta.hit ? f_nx : '0;
         out_ny_ff  <= f_meta.hit ? f_ny : '0;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int v = 0; v <= SW; v++) sq_valid_ff[v] <= 1'b0;
         for (int v = 0; v <= QW; v++) dv_valid_ff[v] <= 1'b0;
      end else if (en) begin
         b1_valid_ff    <= item_valid;
         b2_valid_ff    <= b1_valid_ff;
         sq_valid_ff[0] <= b2_valid_ff;
         for (int v = 0; v < SW; v++) sq_valid_ff[v+1] <= sq_valid_ff[v];
         dv_valid_ff[0] <= sq_valid_ff[SW];
         for (int v = 0; v < QW; v++) dv_valid_ff[v+1] <= dv_valid_ff[v];
         out_valid_ff   <= dv_valid_ff[QW];
      end
   end

endmodule

// ===== tb/tb.sv =====
// Testbench for the shape pair collision test: scoreboard, stimulus and checking.
import spc_pkg::*;

class collision_scoreboard;
   typedef struct {
      logic        hit;
      logic [20:0] depth;
      logic [15:0] nx;
      logic [15:0] ny;
   } contact_type;

   contact_type pending[$];
   int errors;

   function longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function longint clampv(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function longint unsigned root(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function logic [15:0] unit_comp(longint c, longint unsigned s);
      longint unsigned q;
      if (s == 0) return 16'd0;
      q = ((longint'(mag(c)) << 24) + (s >> 1)) / s;
      if (q > 16384) q = 16384;
      return c < 0 ? 16'(-longint'(q)) : 16'(q);
   endfunction

   function contact_type round_contact(longint vx, longint vy, longint unsigned lim);
      contact_type r;
      longint unsigned d2;
      longint unsigned s;
      longint unsigned reach;
      r = '{1'b0, 21'd0, 16'd0, 16'd0};
      d2 = mag(vx) * mag(vx) + mag(vy) * mag(vy);
      if (d2 >= lim * lim) return r;
      s = root(d2 << 20);
      reach = (s + 512) >> 10;
      r.hit = 1'b1;
      r.depth = 21'(lim - reach);
      r.nx = unit_comp(vx, s);
      r.ny = unit_comp(vy, s);
      return r;
   endfunction

   function void note_pair(logic [1:0] shapes, logic [215:0] d);
      contact_type r;
      logic [1:0] pair;
      longint ax, ay, aw, ah, ar, bx, by, bw, bh, br, dx, dy, ox, oy, px, py;
      pair = {shapes[0], shapes[1]};
      ax = longint'($signed(d[23:0]));
      ay = longint'($signed(d[47:24]));
      aw = d[67:48];
      ah = d[87:68];
      ar = d[107:88];
      bx = longint'($signed(d[131:108]));
      by = longint'($signed(d[155:132]));
      bw = d[175:156];
      bh = d[195:176];
      br = d[215:196];
      r = '{1'b0, 21'd0, 16'd0, 16'd0};
      if (pair == PAIR_RECT_RECT) begin
         dx = (2 * bx + bw) - (2 * ax + aw);
         dy = (2 * by + bh) - (2 * ay + ah);
         ox = (aw + bw) - mag(dx);
         oy = (ah + bh) - mag(dy);
         if (ox > 0 && oy > 0) begin
            r.hit = 1'b1;
            if (ox < oy) begin
               r.depth = 21'((ox + 1) >> 1);
               r.nx = dx < 0 ? NEG_ONE_Q14 : POS_ONE_Q14;
            end else begin
               r.depth = 21'((oy + 1) >> 1);
               r.ny = dy < 0 ? NEG_ONE_Q14 : POS_ONE_Q14;
            end
         end
      end else if (pair == PAIR_CIRCLE_CIRCLE) begin
         r = round_contact(bx - ax, by - ay, ar + br);
      end else if (pair == PAIR_CIRCLE_RECT) begin
         px = clampv(ax, bx, bx + bw);
         py = clampv(ay, by, by + bh);
         r = round_contact(px - ax, py - ay, ar);
      end else begin
         px = clampv(bx, ax, ax + aw);
         py = clampv(by, ay, ay + ah);
         r = round_contact(bx - px, by - py, br);
      end
      pending.push_back(r);
   endfunction

   function void check_contact(logic [55:0] d);
      contact_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected transaction %h", $time, d);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (d[0] !== e.hit || d[21:1] !== e.depth || d[37:22] !== e.nx
          || d[53:38] !== e.ny) begin
         $display("%0t: mismatch expected %b %h %h %h actual %b %h %h %h", $time,
                  e.hit, e.depth, e.nx, e.ny, d[0], d[21:1], d[37:22], d[53:38]);
         errors++;
      end
   endfunction
endclass

module tb;
   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [215:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [55:0]  rsp_tdata;

   collision_scoreboard board = new();
   int send_idle = 0;
   int recv_idle = 0;
   int hold_off = 0;

   shape_pair_collision_test dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_contact(rsp_tdata);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);
      end
   end

   function automatic logic [23:0] rand_coord(int mode);
      case (mode)
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom);
         default: return 24'($signed(12'($urandom)));
      endcase
   endfunction

   function automatic logic [19:0] rand_size(int mode);
      case (mode)
         0: return 20'hFFFFF;
         1: return 20'd0;
         2: return 20'($urandom);
         default: return 20'($urandom_range(2048));
      endcase
   endfunction

   task automatic send_pair(logic [1:0] shapes, logic [215:0] d);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= shapes;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_pair(shapes, d);
   endtask

   task automatic send_random(int count);
      logic [215:0] d;
      int m;
      repeat (count) begin
         m = $urandom_range(9) < 8 ? 3 : $urandom_range(3);
         d = {rand_size(m), rand_size(m), rand_size(m), rand_coord(m), rand_coord(m),
              rand_size(m), rand_size(m), rand_size(m), rand_coord(m), rand_coord(m)};
         send_pair(2'($urandom), d);
      end
   endtask

   task automatic drain();
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      while (n < 80) begin
         @(posedge clock);
         n++;
      end
   endtask

   initial begin
      #400000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int s = 0; s < 4; s++) begin
         send_pair(2'(s), '0);
         send_pair(2'(s), {{3{20'hFFFFF}}, 24'h7FFFFF, 24'h7FFFFF,
                           {3{20'hFFFFF}}, 24'h800000, 24'h800000});
         send_pair(2'(s), {20'd256, 40'd512, 24'd0, 24'd0,
                           20'd256, 40'd512, 24'd0, 24'd0});
         send_pair(2'(s), {20'd256, 40'd512, 24'd300, 24'd100,
                           20'd256, 40'd512, 24'd0, 24'd0});
         send_pair(2'(s), {20'd100, 40'd1024, 24'hFFFF00, 24'd700,
                           20'd100, 40'd300, 24'd0, 24'd0});
         send_pair(2'(s), {20'd200, 20'd400, 20'd400, 24'd100, 24'd100,
                           20'd200, 20'd600, 20'd600, 24'd0, 24'd0});
      end
      send_idle = 14;
      recv_idle = 86;
      send_random(150);
      drain();
      send_idle = 86;
      recv_idle = 14;
      send_random(150);
      drain();
      send_idle = 0;
      recv_idle = 0;
      hold_off = 300;
      send_random(150);
      drain();
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/spc_pkg.sv
rtl/spc_front.sv
rtl/spc_queue.sv
rtl/spc_back.sv
rtl/shape_pair_collision_test.sv
tb/tb.sv
